// ===== rtl/spm_pkg.sv =====
package spm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 8;
	localparam int MASK_W   = 16;
	localparam int VOICE_FW = 4;
	localparam int ADDR_FW  = 12;
	localparam int LEN_FW   = 13;
	localparam int LEVEL_W  = 4;

	typedef enum logic [2:0] {
		REQ_WRITE_SAMPLE = 3'd0,
		REQ_SET_LENGTH   = 3'd1,
		REQ_PLAY_MASK    = 3'd2,
		REQ_STOP_ALL     = 3'd3,
		REQ_TICK         = 3'd4
	} spm_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_DRAIN
	} spm_state_t;

	typedef struct packed {
		logic wr_sample;
		logic set_len;
		logic play;
		logic stop_all;
		logic clear;
		logic step;
		logic load_out;
	} spm_cmd_t;

	typedef struct packed {
		logic busy;
	} spm_stat_t;

	// gain = (128*level+9)/10, levels above ten act as ten
	function automatic logic [GAIN_W-1:0] gain_of(input logic [LEVEL_W-1:0] level);
		logic [GAIN_W-1:0] g;
		case (level)
			4'd0:    g = 8'd0;
			4'd1:    g = 8'd13;
			4'd2:    g = 8'd26;
			4'd3:    g = 8'd39;
			4'd4:    g = 8'd52;
			4'd5:    g = 8'd64;
			4'd6:    g = 8'd77;
			4'd7:    g = 8'd90;
			4'd8:    g = 8'd103;
			4'd9:    g = 8'd116;
			default: g = 8'd128;
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/spm_ctrl.sv =====
module spm_ctrl
	import spm_pkg::*;
#(
	parameter int NUM_VOICES = 16,
	localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [2:0]        req_type,
	output logic              m_tvalid,
	input  logic              m_tready,
	output spm_cmd_t          cmd,
	output logic [VIDX_W-1:0] vidx,
	input  spm_stat_t         stat
);

	spm_state_t        state_q, state_nxt;
	logic [VIDX_W-1:0] vcnt_q;
	logic              mval_q;
	logic              accept;
	logic              last_voice;
	logic              out_free;

	assign accept     = s_tvalid && (state_q == ST_IDLE);
	assign last_voice = (vcnt_q == VIDX_W'(NUM_VOICES - 1));
	assign out_free   = !mval_q || m_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == REQ_TICK)) state_nxt = ST_MIX;
			end
			ST_MIX: begin
				if (last_voice) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.busy && out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_WRITE_SAMPLE: cmd.wr_sample = 1'b1;
						REQ_SET_LENGTH:   cmd.set_len   = 1'b1;
						REQ_PLAY_MASK:    cmd.play      = 1'b1;
						REQ_STOP_ALL:     cmd.stop_all  = 1'b1;
						REQ_TICK:         cmd.clear     = 1'b1;
						default:          cmd           = '0;
					endcase
				end
			end
			ST_MIX:   cmd.step     = 1'b1;
			ST_DRAIN: cmd.load_out = !stat.busy && out_free;
			default:  cmd          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vcnt_q  <= '0;
			mval_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.clear) vcnt_q <= '0;
			else if (cmd.step) vcnt_q <= vcnt_q + VIDX_W'(1);
			if (cmd.load_out) mval_q <= 1'b1;
			else if (m_tready) mval_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mval_q;
	assign vidx     = vcnt_q;

endmodule

// ===== rtl/spm_datapath.sv =====
module spm_datapath
	import spm_pkg::*;
#(
	parameter int NUM_VOICES     = 16,
	parameter int ONESHOT_VOICES = 8,
	parameter int WAVE_SAMPLES   = 4096,
	localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [LEVEL_W-1:0]         cfg_wdata,
	input  spm_cmd_t                   cmd,
	input  logic [VIDX_W-1:0]          vidx,
	output spm_stat_t                  stat,
	input  logic [VOICE_FW-1:0]        voice,
	input  logic [ADDR_FW-1:0]         address,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [LEN_FW-1:0]          wave_length,
	input  logic [MASK_W-1:0]          play_mask,
	output logic signed [SAMPLE_W-1:0] mixed_sample
);

	localparam int POS_W     = $clog2(WAVE_SAMPLES);
	localparam int LEN_W     = $clog2(WAVE_SAMPLES + 1);
	localparam int MEM_DEPTH = NUM_VOICES * WAVE_SAMPLES;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	function automatic logic [MEM_AW-1:0] mem_addr(input logic [VIDX_W-1:0] vi,
			input logic [15:0] p);
		return MEM_AW'(vi) * MEM_AW'(WAVE_SAMPLES) + MEM_AW'(p);
	endfunction

	logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];

	logic [LEN_W-1:0]      len_q  [NUM_VOICES];
	logic [POS_W-1:0]      pos_q  [NUM_VOICES];
	logic [NUM_VOICES-1:0] play_q;
	logic [NUM_VOICES-1:0] sel;
	logic [GAIN_W-1:0]     gain_q;

	logic [VIDX_W-1:0] widx;
	logic              voice_ok;
	logic              addr_ok;
	logic [LEN_W-1:0]  new_len;
	logic              gain_nz;

	logic [LEN_W-1:0]  cur_len;
	logic [POS_W-1:0]  cur_pos;
	logic              cur_play;
	logic              oneshot;
	logic              active;
	logic              hit;
	logic              wrap;
	logic [POS_W-1:0]  nxt_pos;

	logic signed [SAMPLE_W-1:0] rd_s1;
	logic                       hit_s1;
	logic                       vld_s1;
	logic signed [23:0]         prod_s2;
	logic                       vld_s2;
	logic signed [24:0]         prod_full;
	logic signed [23:0]         biased;
	logic signed [23:0]         scaled;
	logic signed [17:0]         sum;
	logic signed [SAMPLE_W-1:0] acc_q;
	logic signed [SAMPLE_W-1:0] acc_nxt;
	logic signed [SAMPLE_W-1:0] out_q;

	assign widx     = VIDX_W'(voice);
	assign voice_ok = (32'(voice) < NUM_VOICES);
	assign addr_ok  = (32'(address) < WAVE_SAMPLES);
	assign new_len  = (32'(wave_length) > WAVE_SAMPLES) ? LEN_W'(WAVE_SAMPLES)
	                                                    : LEN_W'(wave_length);
	assign gain_nz  = (gain_q != '0);

	for (genvar i = 0; i < NUM_VOICES; i++) begin : g_sel
		if (i < MASK_W) begin : g_bit
			assign sel[i] = play_mask[i];
		end else begin : g_zero
			assign sel[i] = 1'b0;
		end
	end

	// current voice of the mixing sweep
	assign cur_len  = len_q[vidx];
	assign cur_pos  = pos_q[vidx];
	assign cur_play = play_q[vidx];
	assign oneshot  = (32'(vidx) < ONESHOT_VOICES);
	assign active   = (cur_len != '0) && (cur_play || ((cur_pos != '0) && oneshot));
	assign hit      = active && (LEN_W'(cur_pos) < cur_len);
	assign wrap     = !((LEN_W'(cur_pos) + LEN_W'(1)) < cur_len);
	assign nxt_pos  = wrap ? '0 : cur_pos + POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= gain_of(LEVEL_W'(10));
		end else if (cfg_wen) begin
			gain_q <= gain_of(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				len_q[i] <= '0;
				pos_q[i] <= '0;
			end
			play_q <= '0;
		end else begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				if (cmd.set_len && voice_ok && (widx == VIDX_W'(i))) begin
					len_q[i]  <= new_len;
					pos_q[i]  <= '0;
					play_q[i] <= 1'b0;
				end
				if (cmd.play && gain_nz) begin
					if (sel[i]) begin
						play_q[i] <= 1'b1;
						if (i < ONESHOT_VOICES) pos_q[i] <= '0;
					end else if (i >= ONESHOT_VOICES) begin
						play_q[i] <= 1'b0;
					end
				end
				if (cmd.stop_all && gain_nz) begin
					play_q[i] <= 1'b0;
					pos_q[i]  <= '0;
				end
				if (cmd.step && active && (vidx == VIDX_W'(i))) begin
					pos_q[i] <= nxt_pos;
					if (wrap && oneshot) play_q[i] <= 1'b0;
				end
			end
		end
	end

	// wave memory: write port for loading, read port for the sweep
	always_ff @(posedge clk) begin
		if (cmd.wr_sample && voice_ok && addr_ok)
			mem[mem_addr(widx, 16'(address))] <= sample_in;
		rd_s1 <= mem[mem_addr(vidx, 16'(cur_pos))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
			vld_s2 <= vld_s1;
		end
	end

	assign prod_full = $signed(rd_s1) * $signed({1'b0, gain_q});

	always_ff @(posedge clk) begin
		hit_s1  <= hit;
		prod_s2 <= hit_s1 ? prod_full[23:0] : 24'sd0;
	end

	// divide by 128 truncating toward zero, then saturating add
	assign biased = prod_s2 + (prod_s2[23] ? 24'sd127 : 24'sd0);
	assign scaled = biased >>> 7;
	assign sum    = 18'(acc_q) + 18'(scaled);

	always_comb begin
		if (sum > 18'sd32767) acc_nxt = 16'sh7FFF;
		else if (sum < -18'sd32768) acc_nxt = 16'sh8000;
		else acc_nxt = sum[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) acc_q <= '0;
		else if (vld_s2) acc_q <= acc_nxt;
		if (cmd.load_out) out_q <= acc_q;
	end

	assign stat.busy    = vld_s1 || vld_s2;
	assign mixed_sample = out_q;

endmodule

// ===== rtl/sample_playback_mixer_top.sv =====
// Channel  Dir  Width  Contents
// s_*      in   64     request beat: req_type, voice, address, sample_in, wave_length, play_mask
// m_*      out  16     mixed_sample, one beat per tick request
// cfg_*    in   4      volume_level, written when cfg_wen is high
//
// During a tick the sweep reads one voice's wave sample per cycle from the
// single wave memory read port, then a drain phase empties the multiply and
// accumulate stages. Reset clears voice lengths, positions and play flags and
// sets the gain to full; wave memory is not cleared. A finished mix waits in
// the output register while the next request is taken; a later tick holds in
// its drain phase until that beat is taken.
module sample_playback_mixer_top
	import spm_pkg::*;
#(
	parameter int NUM_VOICES     = 16,
	parameter int ONESHOT_VOICES = 8,
	parameter int WAVE_SAMPLES   = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_type[2:0], voice[6:3], address[18:7], sample_in[34:19],
	// wave_length[47:35], play_mask[63:48]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// mixed_sample[15:0]
	output logic [15:0] m_tdata,
	input  logic        cfg_wen,
	input  logic [3:0]  cfg_wdata
);

	localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	logic [2:0]                 req_type;
	logic [VOICE_FW-1:0]        voice;
	logic [ADDR_FW-1:0]         address;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [LEN_FW-1:0]          wave_length;
	logic [MASK_W-1:0]          play_mask;
	logic signed [SAMPLE_W-1:0] mixed_sample;

	spm_cmd_t          cmd;
	spm_stat_t         stat;
	logic [VIDX_W-1:0] vidx;

	// unpack the request beat
	assign req_type    = s_tdata[2:0];
	assign voice       = s_tdata[6:3];
	assign address     = s_tdata[18:7];
	assign sample_in   = s_tdata[34:19];
	assign wave_length = s_tdata[47:35];
	assign play_mask   = s_tdata[63:48];

	// sequencer: decode requests, sweep voices, hand off the mix
	spm_ctrl #(
		.NUM_VOICES (NUM_VOICES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (req_type),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.vidx     (vidx),
		.stat     (stat)
	);

	// voice state, wave memory, gain and the mixing pipeline
	spm_datapath #(
		.NUM_VOICES     (NUM_VOICES),
		.ONESHOT_VOICES (ONESHOT_VOICES),
		.WAVE_SAMPLES   (WAVE_SAMPLES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.vidx         (vidx),
		.stat         (stat),
		.voice        (voice),
		.address      (address),
		.sample_in    (sample_in),
		.wave_length  (wave_length),
		.play_mask    (play_mask),
		.mixed_sample (mixed_sample)
	);

	assign m_tdata = mixed_sample;

endmodule
